// ----- src/tick_driven_epoch_clock_core_assert.svh -----
// assertion macros for the epoch clock core
`ifndef TICK_DRIVEN_EPOCH_CLOCK_CORE_ASSERT_SVH
`define TICK_DRIVEN_EPOCH_CLOCK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, held off during reset
`define TDEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdec: same-cycle check failed");
// next-cycle implication, held off during reset
`define TDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdec: next-cycle check failed");
`else
`define TDEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/tdec_pkg.sv -----
// types and constants shared by the epoch clock core
`timescale 1ns / 1ps
`default_nettype none

package tdec_pkg;

    // request kinds
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_SET  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_PERIOD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_ENABLE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_INTERVAL = 2'd2;

    // register reset values
    localparam logic [9:0]  TICK_PERIOD_RESET   = 10'd1;
    localparam logic [16:0] SYNC_INTERVAL_RESET = 17'd43200;

    // time constants
    localparam logic [9:0]  MAX_TICK_PERIOD = 10'd1000;
    localparam logic [10:0] MS_PER_SECOND   = 11'd1000;

    // reciprocal multipliers: x/60 = ((x>>2) * m) >> s, exact over the input range
    localparam logic [30:0] DIV60_MULT    = 31'd1145324613; // 30-bit input, shift 34
    localparam logic [25:0] DIV60_M_MULT  = 26'd35791395;   // 25-bit input, shift 29
    // x/24 = ((x>>3) * m) >> 20, exact for an 18-bit input
    localparam logic [18:0] DIV24_MULT    = 19'd349526;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        set_value;
        logic signed [15:0] minute_offset;
    } req_t;

    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] uptime_out;
        logic [31:0] millis_out;
        logic [4:0]  hour_of_day;
        logic [5:0]  minute_of_hour;
        logic [5:0]  second_of_minute;
        logic        sync_request;
    } res_t;

    typedef struct packed {
        logic [9:0]  tick_period_ms;
        logic        sync_enabled;
        logic [16:0] sync_interval_s;
    } cfg_t;

    // clock state right after one request's update
    typedef struct packed {
        logic [31:0]        epoch;
        logic [31:0]        uptime;
        logic [31:0]        millis;
        logic signed [15:0] minute_offset;
        logic               pulse;
    } snap_t;

endpackage

`default_nettype wire

// ----- src/tdec_cfg.sv -----
// configuration registers of the epoch clock core
`timescale 1ns / 1ps
`default_nettype none

module tdec_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tdec_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tdec_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tdec_pkg::cfg_t                           cfg
);

    tdec_pkg::cfg_t cfg_reg;
    tdec_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                tdec_pkg::CFG_TICK_PERIOD:   cfg_next.tick_period_ms  = cfg_data[9:0];
                tdec_pkg::CFG_SYNC_ENABLE:   cfg_next.sync_enabled    = cfg_data[0];
                tdec_pkg::CFG_SYNC_INTERVAL: cfg_next.sync_interval_s = cfg_data[16:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_period_ms  <= tdec_pkg::TICK_PERIOD_RESET;
            cfg_reg.sync_enabled    <= 1'b0;
            cfg_reg.sync_interval_s <= tdec_pkg::SYNC_INTERVAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/tdec_state.sv -----
// clock counters and their per-request update
`timescale 1ns / 1ps
`default_nettype none

module tdec_state (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire tdec_pkg::req_t req,
    input  wire tdec_pkg::cfg_t cfg,
    output tdec_pkg::snap_t     snap
);

    logic [31:0] epoch_reg,  epoch_next;
    logic [31:0] uptime_reg, uptime_next;
    logic [31:0] millis_reg, millis_next;
    logic [10:0] subsec_reg, subsec_next;
    logic [16:0] sync_reg,   sync_next;

    logic [9:0]  period;
    logic [10:0] subsec_sum;
    logic [16:0] sync_inc;
    logic        pulse;

    always_comb
    begin
        period      = (cfg.tick_period_ms > tdec_pkg::MAX_TICK_PERIOD) ?
                      tdec_pkg::MAX_TICK_PERIOD : cfg.tick_period_ms;
        subsec_sum  = subsec_reg + {1'b0, period};
        sync_inc    = sync_reg + 17'd1;
        epoch_next  = epoch_reg;
        uptime_next = uptime_reg;
        millis_next = millis_reg;
        subsec_next = subsec_reg;
        sync_next   = sync_reg;
        pulse       = 1'b0;
        case (req.req_type)
            tdec_pkg::REQ_TICK:
            begin
                millis_next = millis_reg + {22'd0, period};
                subsec_next = subsec_sum;
                if (subsec_sum >= tdec_pkg::MS_PER_SECOND)
                begin
                    subsec_next = subsec_sum - tdec_pkg::MS_PER_SECOND;
                    epoch_next  = epoch_reg + 32'd1;
                    uptime_next = uptime_reg + 32'd1;
                    sync_next   = sync_inc;
                    if (sync_inc >= cfg.sync_interval_s)
                    begin
                        pulse     = cfg.sync_enabled;
                        sync_next = 17'd0;
                    end
                end
            end
            tdec_pkg::REQ_SET:
            begin
                epoch_next = req.set_value;
            end
            default:
            begin
                // read only, the unused code reads as well
                epoch_next = epoch_reg;
            end
        endcase
    end

    assign snap.epoch         = epoch_next;
    assign snap.uptime        = uptime_next;
    assign snap.millis        = millis_next;
    assign snap.minute_offset = req.minute_offset;
    assign snap.pulse         = pulse;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg  <= 32'd0;
            uptime_reg <= 32'd0;
            millis_reg <= 32'd0;
            subsec_reg <= 11'd0;
            sync_reg   <= 17'd0;
        end
        else if (accept)
        begin
            epoch_reg  <= epoch_next;
            uptime_reg <= uptime_next;
            millis_reg <= millis_next;
            subsec_reg <= subsec_next;
            sync_reg   <= sync_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/tdec_tod.sv -----
// time-of-day split and offset stamp, five-stage pipeline with result register
`timescale 1ns / 1ps
`default_nettype none

module tdec_tod (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            snap_valid,
    output logic                 snap_stall,
    input  wire tdec_pkg::snap_t snap,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output tdec_pkg::res_t       res_data
);

    typedef struct packed {
        logic [31:0] epoch;
        logic [26:0] q_min;
        logic [31:0] stamp;
        logic [31:0] uptime;
        logic [31:0] millis;
        logic        pulse;
    } s2_t;

    typedef struct packed {
        logic [26:0] q_min;
        logic [20:0] q_hour;
        logic [5:0]  sec;
        logic [31:0] stamp;
        logic [31:0] uptime;
        logic [31:0] millis;
        logic        pulse;
    } s3_t;

    typedef struct packed {
        logic [20:0] q_hour;
        logic [15:0] q_day;
        logic [5:0]  min;
        logic [5:0]  sec;
        logic [31:0] stamp;
        logic [31:0] uptime;
        logic [31:0] millis;
        logic        pulse;
    } s4_t;

    // stage valids, index 0 is stage one, index 4 the result register
    logic [4:0] vld_reg, vld_next;
    logic [4:0] adv;

    tdec_pkg::snap_t s1_reg;
    s2_t             s2_reg, s2_next;
    s3_t             s3_reg, s3_next;
    s4_t             s4_reg, s4_next;
    tdec_pkg::res_t  s5_reg, s5_next;

    logic [31:0] off_ext;
    logic [31:0] off_x60;
    logic [60:0] prod_min;
    logic [32:0] q_min_x60;
    logic [32:0] sec_rem;
    logic [50:0] prod_hour;
    logic [26:0] q_hour_x60;
    logic [26:0] min_rem;
    logic [36:0] prod_day;
    logic [20:0] q_day_x24;
    logic [20:0] hour_rem;

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        adv[4] = !vld_reg[4] || !res_stall;
        for (int i = 3; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next[0] = adv[0] ? snap_valid : vld_reg[0];
        for (int i = 1; i < 5; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign snap_stall = !adv[0];
    assign res_valid  = vld_reg[4];
    assign res_data   = s5_reg;

    // stage two: offset stamp and minutes quotient
    always_comb
    begin
        off_ext          = {{16{s1_reg.minute_offset[15]}}, s1_reg.minute_offset};
        off_x60          = (off_ext << 6) - (off_ext << 2);
        prod_min         = 61'(s1_reg.epoch[31:2]) * 61'(tdec_pkg::DIV60_MULT);
        s2_next.epoch    = s1_reg.epoch;
        s2_next.q_min    = prod_min[60:34];
        s2_next.stamp    = s1_reg.epoch + off_x60;
        s2_next.uptime   = s1_reg.uptime;
        s2_next.millis   = s1_reg.millis;
        s2_next.pulse    = s1_reg.pulse;
    end

    // stage three: seconds remainder and hours quotient
    always_comb
    begin
        q_min_x60        = {s2_reg.q_min, 6'd0} - {4'd0, s2_reg.q_min, 2'd0};
        sec_rem          = {1'b0, s2_reg.epoch} - q_min_x60;
        prod_hour        = 51'(s2_reg.q_min[26:2]) * 51'(tdec_pkg::DIV60_M_MULT);
        s3_next.q_min    = s2_reg.q_min;
        s3_next.q_hour   = prod_hour[49:29];
        s3_next.sec      = sec_rem[5:0];
        s3_next.stamp    = s2_reg.stamp;
        s3_next.uptime   = s2_reg.uptime;
        s3_next.millis   = s2_reg.millis;
        s3_next.pulse    = s2_reg.pulse;
    end

    // stage four: minutes remainder and days quotient
    always_comb
    begin
        q_hour_x60       = {s3_reg.q_hour, 6'd0} - {4'd0, s3_reg.q_hour, 2'd0};
        min_rem          = s3_reg.q_min - q_hour_x60;
        prod_day         = 37'(s3_reg.q_hour[20:3]) * 37'(tdec_pkg::DIV24_MULT);
        s4_next.q_hour   = s3_reg.q_hour;
        s4_next.q_day    = prod_day[35:20];
        s4_next.min      = min_rem[5:0];
        s4_next.sec      = s3_reg.sec;
        s4_next.stamp    = s3_reg.stamp;
        s4_next.uptime   = s3_reg.uptime;
        s4_next.millis   = s3_reg.millis;
        s4_next.pulse    = s3_reg.pulse;
    end

    // stage five: hour of day into the result register
    always_comb
    begin
        q_day_x24                = {1'b0, s4_reg.q_day, 4'd0} + {2'd0, s4_reg.q_day, 3'd0};
        hour_rem                 = s4_reg.q_hour - q_day_x24;
        s5_next.stamp            = s4_reg.stamp;
        s5_next.uptime_out       = s4_reg.uptime;
        s5_next.millis_out       = s4_reg.millis;
        s5_next.hour_of_day      = hour_rem[4:0];
        s5_next.minute_of_hour   = s4_reg.min;
        s5_next.second_of_minute = s4_reg.sec;
        s5_next.sync_request     = s4_reg.pulse;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 5'd0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_reg <= snap;
        end
        if (adv[1])
        begin
            s2_reg <= s2_next;
        end
        if (adv[2])
        begin
            s3_reg <= s3_next;
        end
        if (adv[3])
        begin
            s4_reg <= s4_next;
        end
        if (adv[4])
        begin
            s5_reg <= s5_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/tick_driven_epoch_clock_core.sv -----
// throughput: one request per cycle while req_stall is low;
// the five-stage time-of-day pipeline sets the latency
// req_stall rises only when all five stages hold requests and the result is stalled
// reset clears the counters and pipeline valids, tick period to 1 ms, sync off,
// sync interval 43200 s
`timescale 1ns / 1ps
`default_nettype none

`include "tick_driven_epoch_clock_core_assert.svh"

module tick_driven_epoch_clock_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // request channel
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire tdec_pkg::req_t                      req_data,
    // result channel
    output logic                                     res_valid,
    input  wire logic                                res_stall,
    output tdec_pkg::res_t                           res_data,
    // configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tdec_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tdec_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tdec_pkg::cfg_t  cfg;
    tdec_pkg::snap_t snap;
    logic            req_accept;

    // the counters step exactly once per accepted request
    assign req_accept = req_valid && !req_stall;

    // tick period, sync enable and sync interval
    tdec_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // epoch, uptime, millisecond and sync counters; snap is the post-update view
    tdec_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (req_accept),
        .req    (req_data),
        .cfg    (cfg),
        .snap   (snap)
    );

    // offset stamp and hour/minute/second split by reciprocal multiplies
    tdec_tod u_tod (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (req_accept),
        .snap_stall (req_stall),
        .snap       (snap),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    // time-of-day fields stay in range
    `TDEC_ASSERT_IMPLY(a_tod_range, clk, rst_n, res_valid,
        (res_data.hour_of_day < 5'd24) && (res_data.minute_of_hour < 6'd60) &&
        (res_data.second_of_minute < 6'd60))
    // the request side only stalls behind a full, stalled pipeline
    `TDEC_ASSERT_IMPLY(a_stall_full, clk, rst_n, req_stall, res_valid && res_stall)
    // a full pipeline keeps its result on the next cycle
    `TDEC_ASSERT_NEXT(a_stall_hold, clk, rst_n, req_stall, res_valid)

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// self-checking testbench for the tick-driven epoch clock core
`timescale 1ns / 1ps

module tb;

    // request kind with no name in the package, the core reads it as a plain read
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam logic [tdec_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned SEC_PER_HOUR = 3600;
    localparam int unsigned SEC_PER_DAY  = 86400;
    localparam int unsigned IDLE_PCT     = 9;
    localparam int unsigned DUT_LATENCY  = 5;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             req_valid = 1'b0;
    logic                             req_stall;
    tdec_pkg::req_t                   req_data = '0;
    logic                             res_valid;
    logic                             res_stall = 1'b0;
    tdec_pkg::res_t                   res_data;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [tdec_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [tdec_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // when set, neither side idles: back-to-back requests and no result stalls
    bit quiet = 1'b0;

    // shadow of the clock state and registers, updated as requests are accepted
    tdec_pkg::cfg_t shadow_cfg;
    logic [31:0]    shadow_epoch;
    logic [31:0]    shadow_uptime;
    logic [31:0]    shadow_millis;
    logic [10:0]    shadow_subsec;
    logic [16:0]    shadow_sync_count;

    // readings the core still owes, oldest first
    tdec_pkg::res_t readings_due[$];
    int             mismatch_count = 0;

    tick_driven_epoch_clock_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // step the shadow clock by one request and return the reading it should give
    function automatic tdec_pkg::res_t advance_clock(tdec_pkg::req_t r);
        tdec_pkg::res_t reading;
        int unsigned    step_ms;
        logic [31:0]    offset_ext;
        logic           pulse;
        pulse = 1'b0;
        if (r.req_type == tdec_pkg::REQ_TICK)
        begin
            step_ms = 32'(shadow_cfg.tick_period_ms);
            // one tick never moves more than a full second
            if (step_ms > 32'(tdec_pkg::MAX_TICK_PERIOD))
                step_ms = 32'(tdec_pkg::MAX_TICK_PERIOD);
            shadow_millis = shadow_millis + step_ms;
            shadow_subsec = 11'(shadow_subsec + step_ms);
            if (shadow_subsec >= tdec_pkg::MS_PER_SECOND)
            begin
                shadow_subsec     = shadow_subsec - tdec_pkg::MS_PER_SECOND;
                shadow_epoch      = shadow_epoch + 32'd1;
                shadow_uptime     = shadow_uptime + 32'd1;
                shadow_sync_count = 17'(shadow_sync_count + 1);
                // greater-or-equal, so a lowered interval clears on the next second
                if (shadow_sync_count >= shadow_cfg.sync_interval_s)
                begin
                    pulse             = shadow_cfg.sync_enabled;
                    shadow_sync_count = '0;
                end
            end
        end
        else if (r.req_type == tdec_pkg::REQ_SET)
        begin
            // a set only moves the epoch, sub-second phase and counters stay
            shadow_epoch = r.set_value;
        end
        offset_ext               = {{16{r.minute_offset[15]}}, r.minute_offset};
        reading.stamp            = shadow_epoch + offset_ext * 32'(SEC_PER_MIN);
        reading.uptime_out       = shadow_uptime;
        reading.millis_out       = shadow_millis;
        reading.hour_of_day      = 5'((shadow_epoch % SEC_PER_DAY) / SEC_PER_HOUR);
        reading.minute_of_hour   = 6'((shadow_epoch % SEC_PER_HOUR) / SEC_PER_MIN);
        reading.second_of_minute = 6'(shadow_epoch % SEC_PER_MIN);
        reading.sync_request     = pulse;
        return reading;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // result side: random stalls, and every accepted reading checked against the oldest due
    always @(posedge clk)
    begin
        if (rst_n)
            res_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        tdec_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (readings_due.size() == 0)
            begin
                $error("reading with none due: 0x%0h", res_data);
                mismatch_count++;
            end
            else
            begin
                want = readings_due.pop_front();
                check_field("stamp", want.stamp, res_data.stamp);
                check_field("uptime_out", want.uptime_out, res_data.uptime_out);
                check_field("millis_out", want.millis_out, res_data.millis_out);
                check_field("hour_of_day", 32'(want.hour_of_day),
                            32'(res_data.hour_of_day));
                check_field("minute_of_hour", 32'(want.minute_of_hour),
                            32'(res_data.minute_of_hour));
                check_field("second_of_minute", 32'(want.second_of_minute),
                            32'(res_data.second_of_minute));
                check_field("sync_request", 32'(want.sync_request),
                            32'(res_data.sync_request));
            end
        end
    end

    // one request: random idle cycles first, then hold until accepted;
    // valid is left high so a following request goes out back to back
    task automatic send_request(logic [1:0] kind, logic [31:0] value, logic [15:0] offset);
        tdec_pkg::req_t r;
        r.req_type      = kind;
        r.set_value     = value;
        r.minute_offset = offset;
        while (!quiet && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        readings_due.push_back(advance_clock(r));
    endtask

    // sender backs off until every reading owed has come out
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
    endtask

    // one register write, the bits above the register's width are random
    task automatic write_reg(logic [tdec_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] word;
        case (idx)
            tdec_pkg::CFG_TICK_PERIOD:   mask = 32'h0000_03FF;
            tdec_pkg::CFG_SYNC_ENABLE:   mask = 32'h0000_0001;
            tdec_pkg::CFG_SYNC_INTERVAL: mask = 32'h0001_FFFF;
            default:                     mask = 32'h0000_0000;
        endcase
        word = ($urandom & ~mask) | (value & mask);
        if (idx == CFG_UNUSED)
            word = $urandom;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            tdec_pkg::CFG_TICK_PERIOD:   shadow_cfg.tick_period_ms  = word[9:0];
            tdec_pkg::CFG_SYNC_ENABLE:   shadow_cfg.sync_enabled    = word[0];
            tdec_pkg::CFG_SYNC_INTERVAL: shadow_cfg.sync_interval_s = word[16:0];
            default:                     ; // no register there, the write is dropped
        endcase
    endtask

    // new settings, written only once the core has nothing in flight
    task automatic configure(logic [9:0] period, logic enable, logic [16:0] interval);
        wait_drained();
        write_reg(tdec_pkg::CFG_TICK_PERIOD, 32'(period));
        write_reg(tdec_pkg::CFG_SYNC_ENABLE, 32'(enable));
        write_reg(tdec_pkg::CFG_SYNC_INTERVAL, 32'(interval));
        cfg_valid <= 1'b0;
    endtask

    // default registers: 1 ms ticks, sync off
    task automatic test_reset_state();
        send_request(tdec_pkg::REQ_READ, 32'h0, 16'h0000);
        send_request(tdec_pkg::REQ_TICK, 32'hDEAD_BEEF, 16'h0000);
        send_request(tdec_pkg::REQ_TICK, 32'h0, 16'h0001);
    endtask

    // offset extremes, stamp wrapping both ways, time of day at its limits
    task automatic test_offsets_and_wrap();
        send_request(tdec_pkg::REQ_SET, 32'hFFFF_FFFF, 16'h7FFF);
        send_request(tdec_pkg::REQ_READ, 32'h0, 16'h8000);
        send_request(REQ_SPARE, $urandom, 16'hFFFF);
        send_request(tdec_pkg::REQ_SET, 32'h0, 16'h8000);
        send_request(tdec_pkg::REQ_SET, 32'(SEC_PER_DAY - 1), 16'h0001);
        send_request(tdec_pkg::REQ_SET, 32'hFFFF_FFFF - 32'(SEC_PER_DAY), 16'h7FFF);
    endtask

    // full-second ticks, epoch wrapping, pulses with a short and a zero interval
    task automatic test_sync_pulses();
        configure(10'd1000, 1'b1, 17'd2);
        send_request(tdec_pkg::REQ_SET, 32'hFFFF_FFFF, 16'h0000);
        repeat (3) send_request(tdec_pkg::REQ_TICK, 32'h0, 16'h0000);
        configure(10'd1000, 1'b1, 17'd0);
        repeat (2) send_request(tdec_pkg::REQ_TICK, 32'h0, 16'h0000);
        // interval reached with sync off: counter clears, no pulse
        configure(10'd1000, 1'b0, 17'd1);
        send_request(tdec_pkg::REQ_TICK, 32'h0, 16'h0000);
    endtask

    // zero period adds nothing, periods past a second saturate
    task automatic test_tick_period_limits();
        configure(10'd0, 1'b1, 17'd1);
        send_request(tdec_pkg::REQ_TICK, 32'h0, 16'h0000);
        configure(10'd1023, 1'b1, 17'd131071);
        repeat (2) send_request(tdec_pkg::REQ_TICK, 32'h0, 16'h0000);
        // index past the register list must change nothing
        wait_drained();
        write_reg(CFG_UNUSED, 32'h0);
        cfg_valid <= 1'b0;
        send_request(tdec_pkg::REQ_TICK, 32'h0, 16'h0000);
    endtask

    // lowering the interval under the running count clears it on the next second
    task automatic test_interval_lowered();
        configure(10'd1000, 1'b1, 17'd5);
        repeat (3) send_request(tdec_pkg::REQ_TICK, 32'h0, 16'h0000);
        configure(10'd1000, 1'b1, 17'd1);
        send_request(tdec_pkg::REQ_TICK, 32'h0, 16'h0000);
    endtask

    // random settings and a random mix of requests; small intervals so pulses show up
    task automatic test_random_traffic(int count, bit no_idle);
        logic [9:0]  period;
        logic [16:0] interval;
        logic [1:0]  kind;
        logic [31:0] value;
        logic [15:0] offset;
        int unsigned pick;
        case ($urandom_range(0, 9))
            0:       period = 10'd0;
            1:       period = 10'($urandom_range(1001, 1023));
            2:       period = 10'd1000;
            3:       period = 10'd1;
            default: period = 10'($urandom_range(1, 1000));
        endcase
        case ($urandom_range(0, 7))
            0:       interval = 17'd0;
            1:       interval = 17'd131071;
            default: interval = 17'($urandom_range(1, 12));
        endcase
        configure(period, 1'($urandom_range(0, 1)), interval);
        quiet = no_idle;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                kind = tdec_pkg::REQ_TICK;
            else if (pick < 72)
                kind = tdec_pkg::REQ_SET;
            else if (pick < 90)
                kind = tdec_pkg::REQ_READ;
            else
                kind = REQ_SPARE;
            // set values: mostly anything, some just under the wrap or a day boundary
            case ($urandom_range(0, 5))
                0:       value = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
                1:       value = 32'($urandom_range(1, 40000)) * 32'(SEC_PER_DAY) - 1;
                default: value = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:       offset = 16'h7FFF;
                1:       offset = 16'h8000;
                default: offset = 16'($urandom);
            endcase
            send_request(kind, value, offset);
            // one pause mid-stream until the core has emptied
            if (i == count / 2)
                wait_drained();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        shadow_cfg.tick_period_ms  = tdec_pkg::TICK_PERIOD_RESET;
        shadow_cfg.sync_enabled    = 1'b0;
        shadow_cfg.sync_interval_s = tdec_pkg::SYNC_INTERVAL_RESET;
        shadow_epoch      = '0;
        shadow_uptime     = '0;
        shadow_millis     = '0;
        shadow_subsec     = '0;
        shadow_sync_count = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_offsets_and_wrap();
        test_sync_pulses();
        test_tick_period_limits();
        test_interval_lowered();
        repeat (4) test_random_traffic(100, 1'b0);
        test_random_traffic(100, 1'b1);

        // let everything out, then watch a little longer for strays
        wait_drained();
        repeat (DUT_LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0 && readings_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
